// ===== src/spq_pkg.sv =====
package spq_pkg;

   // queue geometry
   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // field widths
   localparam int PRIO_W  = 8;
   localparam int LOW_W   = 8;
   localparam int FLAG_W  = 8;
   localparam int PAGES_W = 16;
   localparam int ECNT_W  = 5;

   // operation codes
   typedef enum logic [1:0] {
      CMD_PUSH      = 2'd0,
      CMD_POP_FRONT = 2'd1,
      CMD_POP_BACK  = 2'd2
   } cmd_type;

   // status codes
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // one stored descriptor
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [LOW_W-1:0]   low;
      logic [FLAG_W-1:0]  flags;
      logic [PAGES_W-1:0] pages;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic      push;
      logic      pop_front;
      entry_type item;
   } cell_ctrl_type;

endpackage

// ===== src/spq_cell.sv =====
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          left_le,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output logic          le,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // held entry sorts at or before the pushed descriptor
   assign le = occupied && (entry_ff.prio <= ctrl.item.prio);

   // keep, take the new item, shift from the left or shift from the right
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (!le) begin
            if (left_le) begin
               entry_in = ctrl.item;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctrl.pop_front) begin
         entry_in = right_entry;
      end
   end

   // descriptor storage, no reset needed
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/sorted_priority_queue.sv =====
// a result beat appears in the cycle after its request beat is taken
// throughput: one operation per cycle while results are taken at once; the
// whole row of compare-and-shift cells inserts or removes in parallel
// a pending result that is stalled holds off the next request
// reset clears the count and the result valid; cell storage is not reset
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [LOW_W-1:0]    req_lower_bits,
   input  logic [FLAG_W-1:0]   req_space_flags,
   input  logic [PAGES_W-1:0]  req_pages_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_head_valid,
   output logic [PRIO_W-1:0]   rsp_head_priority,
   output logic [LOW_W-1:0]    rsp_head_lower_bits,
   output logic [FLAG_W-1:0]   rsp_head_flags,
   output logic [PAGES_W-1:0]  rsp_head_pages_free,
   output logic [ECNT_W-1:0]   rsp_entry_count,
   output logic [1:0]          rsp_status
);

   logic          accept;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;
   logic [CNT_W-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   entry_type     cell_entry [DEPTH];
   logic          cell_le [DEPTH];

   // request handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   // command decode
   always_comb begin
      ctrl.push       = 1'b0;
      ctrl.pop_front  = 1'b0;
      ctrl.item.prio  = req_priority_req;
      ctrl.item.low   = req_lower_bits;
      ctrl.item.flags = req_space_flags;
      ctrl.item.pages = req_pages_free;
      count_in        = count_ff;
      status_in       = ST_DONE;
      case (req_cmd)
         CMD_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.push = accept;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               ctrl.pop_front = accept;
               count_in       = count_ff - CNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // status of the last beat
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // row of cells, head at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      occ;
      logic      left_le;
      entry_type left_entry;
      entry_type right_entry;

      assign occ = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_le    = 1'b0;
         assign left_entry = ctrl.item;
      end else begin : g_body
         assign left_le    = cell_le[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .left_le     (left_le),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .le          (cell_le[i]),
         .entry       (cell_entry[i])
      );
   end

   // result beat, taken from the state left by the last operation
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_head_valid      = !empty;
   assign rsp_head_priority   = empty ? '0 : cell_entry[0].prio;
   assign rsp_head_lower_bits = empty ? '0 : cell_entry[0].low;
   assign rsp_head_flags      = empty ? '0 : cell_entry[0].flags;
   assign rsp_head_pages_free = empty ? '0 : cell_entry[0].pages;
   assign rsp_entry_count     = ECNT_W'(count_ff);
   assign rsp_status          = status_ff;

`ifndef SYNTH
   // count stays within the row
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count beyond depth");

   // an accepted push with room grows the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_PUSH && !full) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow count");

   // the two leading entries are in order
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> cell_entry[0].prio <= cell_entry[1].prio)
      else $error("head entries out of order");

   // a pop on an empty queue is flagged
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && empty && (req_cmd == CMD_POP_FRONT || req_cmd == CMD_POP_BACK))
      |=> rsp_valid && rsp_status == ST_EMPTY && count_ff == '0)
      else $error("empty pop not flagged");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import spq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // the unused fourth command code, a no-op
   localparam logic [1:0] CMD_NOP = 2'd3;

   // priorities used to fill the queue, with repeats and both extremes
   localparam logic [7:0] FILL_PRIO [16] = '{
      8'd128, 8'd0,   8'd255, 8'd128, 8'd128, 8'd0,   8'd255, 8'd64,
      8'd128, 8'd1,   8'd254, 8'd0,   8'd255, 8'd128, 8'd64,  8'd128
   };

   // what one result beat reports
   typedef struct packed {
      logic               valid;
      logic [PRIO_W-1:0]  prio;
      logic [LOW_W-1:0]   low;
      logic [FLAG_W-1:0]  flags;
      logic [PAGES_W-1:0] pages;
      logic [ECNT_W-1:0]  count;
      status_type         status;
   } head_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_cmd = CMD_PUSH;
   logic [PRIO_W-1:0]   req_priority_req = '0;
   logic [LOW_W-1:0]    req_lower_bits = '0;
   logic [FLAG_W-1:0]   req_space_flags = '0;
   logic [PAGES_W-1:0]  req_pages_free = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_head_valid;
   logic [PRIO_W-1:0]   rsp_head_priority;
   logic [LOW_W-1:0]    rsp_head_lower_bits;
   logic [FLAG_W-1:0]   rsp_head_flags;
   logic [PAGES_W-1:0]  rsp_head_pages_free;
   logic [ECNT_W-1:0]   rsp_entry_count;
   logic [1:0]          rsp_status;

   // shadow of the sorted store and the reports still owed
   entry_type           sorted_shadow [DEPTH];
   int                  held_count = 0;
   head_report_type     pending_reports [$];
   int                  fail_count = 0;
   int                  burst_left = 0;
   int                  stall_mode = 0;
   int                  stall_left = 0;

   sorted_priority_queue u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_priority_req    (req_priority_req),
      .req_lower_bits      (req_lower_bits),
      .req_space_flags     (req_space_flags),
      .req_pages_free      (req_pages_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_priority   (rsp_head_priority),
      .rsp_head_lower_bits (rsp_head_lower_bits),
      .rsp_head_flags      (rsp_head_flags),
      .rsp_head_pages_free (rsp_head_pages_free),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_status          (rsp_status)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // apply one operation to the shadow queue and report the new head
   function automatic head_report_type apply_queue_op(input logic [1:0] op,
                                                      input entry_type item);
      head_report_type rep;
      int              slot;
      int              i;
      rep = '0;
      rep.status = ST_DONE;
      case (op)
         CMD_PUSH: begin
            if (held_count >= DEPTH) begin
               rep.status = ST_FULL;
            end else begin
               // equal priorities go behind the ones already held
               slot = 0;
               while (slot < held_count && sorted_shadow[slot].prio <= item.prio)
                  slot++;
               for (i = held_count; i > slot; i--)
                  sorted_shadow[i] = sorted_shadow[i-1];
               sorted_shadow[slot] = item;
               held_count++;
            end
         end
         CMD_POP_FRONT: begin
            if (held_count == 0) begin
               rep.status = ST_EMPTY;
            end else begin
               for (i = 0; i + 1 < held_count; i++)
                  sorted_shadow[i] = sorted_shadow[i+1];
               held_count--;
            end
         end
         CMD_POP_BACK: begin
            if (held_count == 0)
               rep.status = ST_EMPTY;
            else
               held_count--;
         end
         default: begin
         end
      endcase
      if (held_count > 0) begin
         rep.valid = 1'b1;
         rep.prio  = sorted_shadow[0].prio;
         rep.low   = sorted_shadow[0].low;
         rep.flags = sorted_shadow[0].flags;
         rep.pages = sorted_shadow[0].pages;
      end
      rep.count = ECNT_W'(held_count);
      return rep;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // record every request beat taken, check every result beat taken
   always @(posedge clock) begin
      head_report_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_reports.push_back(apply_queue_op(req_cmd,
               {req_priority_req, req_lower_bits, req_space_flags, req_pages_free}));
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("result beat with no request outstanding");
               fail_count++;
            end else begin
               want = pending_reports.pop_front();
               compare_field("head_valid", 32'(want.valid), 32'(rsp_head_valid));
               compare_field("head_priority", 32'(want.prio), 32'(rsp_head_priority));
               compare_field("head_lower_bits", 32'(want.low), 32'(rsp_head_lower_bits));
               compare_field("head_flags", 32'(want.flags), 32'(rsp_head_flags));
               compare_field("head_pages_free", 32'(want.pages),
                             32'(rsp_head_pages_free));
               compare_field("entry_count", 32'(want.count), 32'(rsp_entry_count));
               compare_field("status", 32'(want.status), 32'(rsp_status));
            end
         end
      end
   end

   // receiver back-pressure: free, light, heavy or toggling, in stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   // send one request beat, with bursts and idle gaps between them
   task automatic send_beat(input logic [1:0] op, input logic [7:0] prio,
                            input logic [7:0] low, input logic [7:0] flags,
                            input logic [15:0] pages);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_cmd          <= op;
      req_priority_req <= prio;
      req_lower_bits   <= low;
      req_space_flags  <= flags;
      req_pages_free   <= pages;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // pops and the no-op on an empty queue
   task automatic test_empty_queue();
      send_beat(CMD_POP_FRONT, 8'h00, 8'h00, 8'h00, 16'h0000);
      send_beat(CMD_POP_BACK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_beat(CMD_NOP, 8'h5A, 8'hA5, 8'h3C, 16'hC33C);
   endtask

   // fill to the brim with repeated and extreme keys, then push when full, a no-op and both pops
   task automatic test_fill_to_overflow();
      logic [7:0]  low;
      logic [15:0] pages;
      for (int i = 0; i < DEPTH; i++) begin
         low = 8'(i * 17);
         pages = (i == 0) ? 16'h0000 : (i == DEPTH - 1) ? 16'hFFFF : {low, ~low};
         send_beat(CMD_PUSH, FILL_PRIO[i % 16], low, ~low, pages);
      end
      send_beat(CMD_PUSH, 8'h00, 8'hEE, 8'hEE, 16'hEEEE);
      send_beat(CMD_NOP, 8'h00, 8'h00, 8'h00, 16'h0000);
      send_beat(CMD_POP_BACK, 8'h00, 8'h00, 8'h00, 16'h0000);
      send_beat(CMD_POP_FRONT, 8'h00, 8'h00, 8'h00, 16'h0000);
   endtask

   // random mix; push bias drifts so the queue swings between empty and full
   task automatic test_random_ops();
      int         push_bias;
      bit         narrow_keys;
      int         r;
      logic [1:0] op;
      logic [7:0] prio;
      push_bias = 50;
      narrow_keys = 1'b0;
      for (int k = 0; k < 850; k++) begin
         if (k % 40 == 0) begin
            push_bias = $urandom_range(15, 85);
            narrow_keys = ($urandom_range(0, 1) == 1);
         end
         r = $urandom_range(0, 99);
         if (r < 3)
            op = CMD_NOP;
         else if (r < 3 + push_bias * 97 / 100)
            op = CMD_PUSH;
         else if ($urandom_range(0, 1) == 1)
            op = CMD_POP_FRONT;
         else
            op = CMD_POP_BACK;
         // a narrow key set gives many equal priorities
         if (narrow_keys)
            prio = 8'($urandom_range(0, 3) * 85);
         else
            prio = 8'($urandom_range(0, 255));
         send_beat(op, prio, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)));
      end
   endtask

   // sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_to_overflow();
      test_random_ops();
      req_valid <= 1'b0;
      // let the checker record the last request beat before draining
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
